[sv/dptfa_pkg.sv]
// ----------------------------------------------------------------------------
// Demand page table package
// Result codes and configuration register indexes shared by the page table.
// ----------------------------------------------------------------------------
package dptfa_pkg;

  // Result code returned with every item.
  typedef enum logic [1:0] {
    STATUS_HIT      = 2'd0,
    STATUS_LOADED   = 2'd1,
    STATUS_INVALID  = 2'd2,
    STATUS_NO_FRAME = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 9;
  localparam logic [CFG_AW-1:0] REG_PAGES_IN_USE  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_FRAMES_IN_USE = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [8:0] PAGES_IN_USE_RST  = 9'd256;
  localparam logic [7:0] FRAMES_IN_USE_RST = 8'd100;

  // Fixed field widths of the stream payload.
  localparam int unsigned PAGE_NUM_W  = 8;
  localparam int unsigned FRAME_NUM_W = 7;

endpackage

[sv/dptfa_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dptfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/demand_page_table_frame_alloc.sv]
// ----------------------------------------------------------------------------
// Demand page table with frame allocation
// Resolves page accesses to physical frames, claiming a new frame on a miss.
// ----------------------------------------------------------------------------
// Usage:
// Each input item on the s_* channel is one page access: the page number in
// s_tdata and the write flag in s_tuser. Each access yields exactly one item
// on the m_* channel: the frame number in m_tdata and a result code in
// m_tuser (hit, loaded into a new frame, invalid page, no free frame).
// The page table lives in one synchronous RAM with registered read data.
// An access is accepted and its table entry is read; in the lookup state,
// once the output register is free, the entry is updated and written back
// and the result is loaded into the output register. This read-then-write
// of the page table RAM means a new access is not accepted while one is
// still in its lookup state. A new access is accepted while a finished
// result still waits in the output register; if the receiver stalls, the
// following access waits in its lookup state until the output register is
// free, and s_tready stays low meanwhile.
// Frames are never released, so they are handed out in ascending order and
// a single count of used frames gives the lowest free frame.
// After reset the block sweeps the page table once to clear it, one entry a
// cycle, through all MAX_PAGES entries; s_tready stays low during the sweep while
// configuration writes are taken as usual.
// ----------------------------------------------------------------------------
module demand_page_table_frame_alloc #(
  parameter int unsigned MAX_PAGES  = 256,
  parameter int unsigned MAX_FRAMES = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [dptfa_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [dptfa_pkg::CFG_DW-1:0]   cfg_wdata,
  // Access stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] page_number
  input  logic                           s_tuser,   // [0] is_write
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [6:0] frame_number, [7] zero
  output logic [1:0]                     m_tuser    // [1:0] status
);

  localparam int unsigned PAW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned FAW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned FCW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PCW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned PLW   = (PCW > 9) ? PCW : 9;
  localparam int unsigned FLW   = (FCW > 8) ? FCW : 8;
  localparam int unsigned ENT_W = FAW + 3;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                          state, state_next;
  logic [PAW-1:0]                  clr_addr;
  logic [8:0]                      pages_in_use;
  logic [7:0]                      frames_in_use;
  logic [FCW-1:0]                  frames_used;

  // Access held for its lookup cycle.
  logic [PAW-1:0]                  req_page;
  logic                            req_write;
  logic                            req_invalid;

  // Output register.
  logic [dptfa_pkg::FRAME_NUM_W-1:0] out_frame;
  dptfa_pkg::status_t              out_status;

  // Page table RAM ports.
  logic                            ram_we;
  logic [PAW-1:0]                  ram_waddr;
  logic [ENT_W-1:0]                ram_wdata;
  logic                            ram_re;
  logic [ENT_W-1:0]                ram_rdata;

  // Entry layout: {resident, referenced, dirty, frame}.
  logic                            ent_resident;
  logic                            ent_dirty;
  logic [FAW-1:0]                  ent_frame;

  logic                            in_accept;
  logic                            out_free;
  logic                            page_invalid;
  logic                            frames_full;
  logic                            finish;
  dptfa_pkg::status_t              res_status;
  logic [dptfa_pkg::FRAME_NUM_W-1:0] res_frame;
  logic                            claim;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign finish    = (state == ST_LOOK) && out_free;

  assign m_tdata = {1'b0, out_frame};
  assign m_tuser = out_status;

  // A page at or above either the register or the table depth is invalid.
  assign page_invalid = (PLW'(s_tdata) >= PLW'(pages_in_use)) ||
                        (PLW'(s_tdata) >= PLW'(MAX_PAGES));

  // The next frame to hand out is frames_used; none left once it reaches
  // the frame limit.
  assign frames_full = (FLW'(frames_used) >= FLW'(frames_in_use)) ||
                       (FLW'(frames_used) >= FLW'(MAX_FRAMES));

  assign ent_resident = ram_rdata[FAW+2];
  assign ent_dirty    = ram_rdata[FAW];
  assign ent_frame    = ram_rdata[FAW-1:0];

  dptfa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (PAW'(s_tdata)),
    .rdata (ram_rdata)
  );

  // Lookup decision and the entry to write back.
  always_comb begin
    res_status = dptfa_pkg::STATUS_INVALID;
    res_frame  = '0;
    claim      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = req_page;
    ram_wdata  = '0;
    ram_re     = in_accept;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (req_invalid) begin
      res_status = dptfa_pkg::STATUS_INVALID;
    end else if (ent_resident) begin
      // Hit: mark referenced; the dirty mark is sticky.
      res_status = dptfa_pkg::STATUS_HIT;
      res_frame  = dptfa_pkg::FRAME_NUM_W'(ent_frame);
      ram_we     = finish;
      ram_wdata  = {1'b1, 1'b1, ent_dirty | req_write, ent_frame};
    end else if (frames_full) begin
      res_status = dptfa_pkg::STATUS_NO_FRAME;
    end else begin
      // Miss: bind the lowest free frame to the page.
      res_status = dptfa_pkg::STATUS_LOADED;
      res_frame  = dptfa_pkg::FRAME_NUM_W'(frames_used);
      claim      = finish;
      ram_we     = finish;
      ram_wdata  = {1'b1, 1'b1, req_write, FAW'(frames_used)};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == PAW'(MAX_PAGES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      frames_used   <= '0;
      pages_in_use  <= dptfa_pkg::PAGES_IN_USE_RST;
      frames_in_use <= dptfa_pkg::FRAMES_IN_USE_RST;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= PAW'(clr_addr + 1'b1);
      end
      if (claim) begin
        frames_used <= FCW'(frames_used + 1'b1);
      end
      if (cfg_we) begin
        case (cfg_addr)
          dptfa_pkg::REG_PAGES_IN_USE:  pages_in_use  <= cfg_wdata;
          dptfa_pkg::REG_FRAMES_IN_USE: frames_in_use <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_page    <= PAW'(s_tdata);
      req_write   <= s_tuser;
      req_invalid <= page_invalid;
    end
    if (finish) begin
      out_status <= res_status;
      out_frame  <= res_frame;
    end
  end

endmodule
